[rtl/sps_pkg.sv]
// Shared types, widths and register codes of the segmented prime sieve.
// Used by sps_front, sps_back and the top level in rtl/; depends on nothing.
`default_nettype none

package sps_pkg;

  localparam int LOW_W       = 40;
  localparam int COUNT_W     = 11;
  localparam int PRIME_W     = 20;
  localparam int OFF_W       = PRIME_W + 1;
  localparam int WORD_W      = 64;
  localparam int IDX_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 40;
  localparam int SEG_LEN_DEF = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 11'd1024;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_COUNT = 2'd1;

  typedef struct packed {
    logic [PRIME_W-1:0] base_prime;
    logic               last_prime;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] map_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
  } out_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [OFF_W-1:0]   off;
    logic               skip;
    logic               last;
  } job_t;

endpackage

`default_nettype wire

[rtl/sps_fifo.sv]
// Small register queue used between the sieve stages and at the result side.
// Stand-alone; no package dependency.
`default_nettype none

module sps_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return ptr + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sps_front.sv]
// Front stage: takes a base prime, divides the segment base by it bit-serially
// and forms the first offset to mark. Depends on sps_pkg.
`default_nettype none

module sps_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire sps_pkg::in_t                   item_i,
  output logic                                busy_o,
  input  wire logic [sps_pkg::LOW_W-1:0]      seg_low_i,
  output logic                                job_push_o,
  output sps_pkg::job_t                       job_o,
  input  wire logic                           job_full_i
);

  localparam int CNT_W = $clog2(sps_pkg::LOW_W);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_DONE
  } state_e;

  state_e                         state_q;
  logic [sps_pkg::PRIME_W-1:0]    p_q, rem_q, rem_d;
  logic [sps_pkg::LOW_W-1:0]      low_q, dvd_q;
  logic [CNT_W-1:0]               cnt_q;
  logic                           last_q;
  logic [sps_pkg::PRIME_W:0]      trial;
  logic [sps_pkg::OFF_W-1:0]      twice_p, off;

  assign busy_o = (state_q != F_IDLE);

  always_comb begin
    trial = {rem_q, dvd_q[sps_pkg::LOW_W-1]};
    if (trial >= {1'b0, p_q}) begin
      rem_d = sps_pkg::PRIME_W'(trial - {1'b0, p_q});
    end else begin
      rem_d = sps_pkg::PRIME_W'(trial);
    end
  end

  always_comb begin
    twice_p = {p_q, 1'b0};
    priority if (low_q == '0) begin
      off = twice_p;
    end else if (low_q <= sps_pkg::LOW_W'(p_q)) begin
      off = twice_p - sps_pkg::OFF_W'(low_q);
    end else if (rem_q == '0) begin
      off = '0;
    end else begin
      off = sps_pkg::OFF_W'(p_q) - sps_pkg::OFF_W'(rem_q);
    end
  end

  assign job_o.prime = p_q;
  assign job_o.off   = off;
  assign job_o.skip  = (p_q == '0);
  assign job_o.last  = last_q;
  assign job_push_o  = (state_q == F_DONE) && !job_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      p_q     <= '0;
      rem_q   <= '0;
      low_q   <= '0;
      dvd_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            p_q     <= item_i.base_prime;
            last_q  <= item_i.last_prime;
            low_q   <= seg_low_i;
            dvd_q   <= seg_low_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[sps_pkg::LOW_W-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(sps_pkg::LOW_W - 1)) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (!job_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sps_back.sv]
// Back stage: composite map memory, its clearing, marking of multiples and map emission.
// Depends on sps_pkg; fed by the job queue, feeds the result queue.
`default_nettype none

module sps_back #(
  parameter int SEG_LEN = sps_pkg::SEG_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [sps_pkg::COUNT_W-1:0]   seg_count_i,
  input  wire sps_pkg::job_t                 job_i,
  input  wire logic                          job_empty_i,
  output logic                               job_pop_o,
  output logic                               clearing_o,
  output logic                               out_push_o,
  output sps_pkg::out_t                      out_o,
  input  wire logic                          out_full_i
);

  localparam int MAP_WORDS = (SEG_LEN + 63) / 64;
  localparam int ROW_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int N_W       = $clog2(SEG_LEN + 1);
  localparam int POS_W     = sps_pkg::OFF_W + 1;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_RD,
    B_WAIT,
    B_MARK,
    B_ERD,
    B_EWR
  } state_e;

  state_e                         state_q;
  logic [sps_pkg::WORD_W-1:0]     mem_q [MAP_WORDS];
  logic [sps_pkg::WORD_W-1:0]     rd_q, buf_q, wdata;
  logic [ROW_W-1:0]               sweep_q, cur_row_q, waddr, raddr, off_row;
  logic [POS_W-1:0]               off_q;
  logic [sps_pkg::PRIME_W-1:0]    p_q;
  logic                           last_q;
  logic                           we, re, in_seg, hit, in_range, advance, sweep_end;
  logic [N_W-1:0]                 n;
  logic [N_W:0]                   n_up;
  logic [ROW_W:0]                 words;

  always_comb begin
    if (32'(seg_count_i) > 32'(SEG_LEN)) begin
      n = N_W'(SEG_LEN);
    end else begin
      n = N_W'(seg_count_i);
    end
    n_up = ({1'b0, n} + (N_W + 1)'(63)) >> 6;
    if (n_up == '0) begin
      words = (ROW_W + 1)'(1);
    end else begin
      words = (ROW_W + 1)'(n_up);
    end
  end

  assign off_row   = off_q[6 +: ROW_W];
  assign in_seg    = (off_q < POS_W'(n));
  assign hit       = in_seg && (off_row == cur_row_q);
  assign in_range  = ({1'b0, sweep_q} < words);
  assign advance   = (state_q == B_EWR) && (!in_range || !out_full_i);
  assign sweep_end = (sweep_q == ROW_W'(MAP_WORDS - 1));

  assign clearing_o = (state_q == B_CLR);
  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i;
  assign out_push_o = (state_q == B_EWR) && in_range && !out_full_i;

  assign out_o.map_word   = rd_q;
  assign out_o.word_index = sps_pkg::IDX_W'(sweep_q);
  assign out_o.last_word  = ({1'b0, sweep_q} == (words - (ROW_W + 1)'(1)));

  always_comb begin
    we    = 1'b0;
    waddr = sweep_q;
    wdata = '0;
    re    = 1'b0;
    raddr = sweep_q;
    unique case (state_q)
      B_CLR: we = 1'b1;
      B_MARK: begin
        if (!hit) begin
          we    = 1'b1;
          waddr = cur_row_q;
          wdata = buf_q;
        end
      end
      B_RD: begin
        re    = in_seg;
        raddr = off_row;
      end
      B_ERD: re = 1'b1;
      B_EWR: we = advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLR;
      sweep_q   <= '0;
      cur_row_q <= '0;
      off_q     <= '0;
      p_q       <= '0;
      last_q    <= 1'b0;
      buf_q     <= '0;
    end else begin
      unique case (state_q)
        B_CLR: begin
          if (sweep_end) begin
            sweep_q <= '0;
            state_q <= B_IDLE;
          end else begin
            sweep_q <= sweep_q + ROW_W'(1);
          end
        end
        B_IDLE: begin
          if (!job_empty_i) begin
            p_q    <= job_i.prime;
            off_q  <= POS_W'(job_i.off);
            last_q <= job_i.last;
            priority if (!job_i.skip) begin
              state_q <= B_RD;
            end else if (job_i.last) begin
              state_q <= B_ERD;
            end
          end
        end
        B_RD: begin
          if (in_seg) begin
            cur_row_q <= off_row;
            state_q   <= B_WAIT;
          end else if (last_q) begin
            state_q <= B_ERD;
          end else begin
            state_q <= B_IDLE;
          end
        end
        B_WAIT: begin
          buf_q   <= rd_q;
          state_q <= B_MARK;
        end
        B_MARK: begin
          if (hit) begin
            buf_q <= buf_q | (sps_pkg::WORD_W'(1) << off_q[5:0]);
            off_q <= off_q + POS_W'(p_q);
          end else begin
            state_q <= B_RD;
          end
        end
        B_ERD: state_q <= B_EWR;
        B_EWR: begin
          if (advance) begin
            if (sweep_end) begin
              sweep_q <= '0;
              state_q <= B_IDLE;
            end else begin
              sweep_q <= sweep_q + ROW_W'(1);
              state_q <= B_ERD;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/segmented_prime_sieve_core.sv]
// Top level of the segmented prime sieve: config registers, front, job queue,
// back and result queue. Depends on sps_pkg, sps_front, sps_fifo, sps_back.
//
//   channel   ports                                   transaction when
//   input     push, full, in_item_i                   push && !full
//   result    empty, pop, out_item_o                  pop && !empty
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i        cfg_we_i
//
// Front: one prime at a time through the bit-serial 40-step remainder unit; full stays high
//   until its job is queued. Back: takes a job, reads each touched map word, sets one bit per
//   mark and writes it back; a final prime then sweeps all SEG_LEN/64 map words, emitting those
//   in the segment and clearing each. After reset the map is swept clear with full high.
// The job and result queues let the front accept while the back marks or waits on pop.
`default_nettype none

module segmented_prime_sieve_core #(
  parameter int SEG_LEN = sps_pkg::SEG_LEN_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire sps_pkg::in_t                      in_item_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output sps_pkg::out_t                          out_item_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic [sps_pkg::LOW_W-1:0]   seg_low_q;
  logic [sps_pkg::COUNT_W-1:0] seg_count_q;
  logic                        front_busy, clearing;
  logic                        mid_push, mid_full, mid_pop, mid_empty;
  logic                        out_push, out_full;
  sps_pkg::job_t               job_in, job_out;
  sps_pkg::out_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_low_q   <= '0;
      seg_count_q <= sps_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sps_pkg::REG_SEG_LOW) begin
        seg_low_q <= cfg_wdata_i[sps_pkg::LOW_W-1:0];
      end else if (cfg_idx_i == sps_pkg::REG_SEG_COUNT) begin
        seg_count_q <= cfg_wdata_i[sps_pkg::COUNT_W-1:0];
      end
    end
  end

  assign full = front_busy || clearing;

  sps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push && !full),
    .item_i     (in_item_i),
    .busy_o     (front_busy),
    .seg_low_i  (seg_low_q),
    .job_push_o (mid_push),
    .job_o      (job_in),
    .job_full_i (mid_full)
  );

  sps_fifo #(
    .W     ($bits(sps_pkg::job_t)),
    .DEPTH (sps_pkg::QUEUE_DEPTH)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (job_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (job_out),
    .empty_o (mid_empty)
  );

  sps_back #(
    .SEG_LEN (SEG_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_count_i (seg_count_q),
    .job_i       (job_out),
    .job_empty_i (mid_empty),
    .job_pop_o   (mid_pop),
    .clearing_o  (clearing),
    .out_push_o  (out_push),
    .out_o       (res),
    .out_full_i  (out_full)
  );

  sps_fifo #(
    .W     ($bits(sps_pkg::out_t)),
    .DEPTH (sps_pkg::QUEUE_DEPTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef ASSERT_OFF
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("front not busy after taking a prime");

  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("job pushed into full queue");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  a_no_pop_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !mid_pop && !out_push)
    else $error("back active during clearing sweep");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for segmented_prime_sieve_core: directed and random
// base primes with register changes, checked word by word against a composite map.
// Depends on rtl/sps_pkg.sv and rtl/segmented_prime_sieve_core.sv.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 260;
  localparam int MAX_GAP       = 8;
  localparam int MAP_WORDS     = SEG_LEN_DEF / 64;
  localparam int CLEAR_WAIT    = 2 * MAP_WORDS + 32;
  localparam int DRAIN_WAIT    = 6000;
  localparam longint LIMIT_NS  = 64'd40_000_000;
  localparam int unsigned PRIME_MAX     = 20'hFFFFF;
  localparam int unsigned LARGEST_PRIME = 1048573;
  localparam logic [LOW_W-1:0]     LOW_MAX   = 40'hFF_FFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  class composite_map_sb;
    logic [LOW_W-1:0]   low;
    logic [COUNT_W-1:0] count;
    bit [WORD_W-1:0]    map [MAP_WORDS];
    out_t               words_due [$];
    int                 errors;

    function new();
      low    = '0;
      count  = COUNT_RESET;
      errors = 0;
      foreach (map[i]) map[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SEG_LOW:   low = data[LOW_W-1:0];
        REG_SEG_COUNT: count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_prime(in_t item);
      bit [63:0] p;
      bit [63:0] n;
      bit [63:0] k;
      bit [63:0] off;
      bit [63:0] words;
      out_t      word;
      p = 64'(item.base_prime);
      n = (count > SEG_LEN_DEF) ? 64'(SEG_LEN_DEF) : 64'(count);
      if (p != 0 && n != 0) begin
        k = 64'(low) / p + ((64'(low) % p != 0) ? 64'd1 : 64'd0);
        if (k < 2) k = 2;
        off = k * p - 64'(low);
        while (off < n) begin
          map[(off >> 6) % MAP_WORDS][off[5:0]] = 1'b1;
          off += p;
        end
      end
      if (!item.last_prime) return;
      words = (n + 63) / 64;
      if (words == 0) words = 1;
      for (int w = 0; w < words; w++) begin
        word.map_word   = map[w];
        word.word_index = w[IDX_W-1:0];
        word.last_word  = (w + 1 == words);
        words_due = {words_due, word};
      end
      foreach (map[i]) map[i] = '0;
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (words_due.size() == 0) begin
        $error("unexpected result: word_index %0d map_word %h", got.word_index, got.map_word);
        errors++;
        return;
      end
      want = words_due.pop_front();
      if (got.map_word !== want.map_word) begin
        $error("map_word: expected %h, actual %h", want.map_word, got.map_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0d, actual %0d", want.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  in_t                   in_item_i   = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  out_t                  out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  composite_map_sb sb = new();
  bit              quiet = 1'b0;
  bit              tail_done = 1'b1;
  int unsigned     primes_sent = 0;

  segmented_prime_sieve_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_wdata_i);
      if (push && !full) sb.note_prime(in_item_i);
      if (pop && !empty) sb.check_word(out_item_o);
    end
  end

  function automatic int unsigned prime_at_or_above(int unsigned v);
    int unsigned c;
    bit          composite;
    c = (v < 2) ? 2 : v;
    if (c > LARGEST_PRIME) c = LARGEST_PRIME;
    do begin
      composite = 1'b0;
      for (int unsigned d = 2; d * d <= c; d++) begin
        if (c % d == 0) composite = 1'b1;
      end
      c++;
    end while (composite);
    return c - 1;
  endfunction

  task automatic send_prime(input int unsigned p, input bit last);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= '{base_prime: PRIME_W'(p), last_prime: last};
    do @(posedge clk_i); while (full);
    primes_sent++;
    tail_done = last;
  endtask

  // Drop push, drain all expected words, then let the back end go quiet.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.words_due.size() != 0) @(posedge clk_i);
    repeat (tail_done ? CLEAR_WAIT : DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned      stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin
    int unsigned        len;
    int unsigned        p;
    int unsigned        rand_start;
    logic [LOW_W-1:0]   low_val;
    logic [COUNT_W-1:0] cnt;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (full);

    // reset register values
    send_prime(2, 1'b0);
    send_prime(3, 1'b0);
    send_prime(31, 1'b1);
    settle();

    // top of the range, clipped count, all-ones base, base one, base zero
    write_reg(REG_SEG_LOW, CFG_DATA_W'(LOW_MAX));
    write_reg(REG_SEG_COUNT, CFG_DATA_W'(11'h7FF));
    send_prime(PRIME_MAX, 1'b0);
    send_prime(1, 1'b0);
    send_prime(0, 1'b1);
    settle();

    write_reg(REG_SEG_LOW, '0);
    write_reg(REG_SEG_COUNT, CFG_DATA_W'(1));
    send_prime(1, 1'b1);
    settle();
    write_reg(REG_SEG_COUNT, '0);
    send_prime(7, 1'b1);
    settle();

    // change the base between primes; the map must survive
    write_reg(REG_SEG_LOW, CFG_DATA_W'(100));
    write_reg(REG_SEG_COUNT, CFG_DATA_W'(64));
    send_prime(3, 1'b0);
    send_prime(4, 1'b0);
    settle();
    write_reg(REG_SEG_LOW, CFG_DATA_W'(1000));
    write_reg(REG_SPARE, '1);
    send_prime(5, 1'b1);
    settle();

    write_reg(REG_SEG_LOW, CFG_DATA_W'(40'h10_0000));
    write_reg(REG_SEG_COUNT, CFG_DATA_W'(65));
    send_prime(2, 1'b0);
    send_prime(32'h80000, 1'b0);
    send_prime(1021, 1'b1);
    settle();

    rand_start = primes_sent;
    while (primes_sent - rand_start < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        settle();
        case ($urandom_range(0, 3))
          0: low_val = LOW_W'($urandom_range(0, 4096));
          1: low_val = {8'($urandom_range(0, 255)), 32'($urandom())};
          2: low_val = LOW_MAX - LOW_W'($urandom_range(0, 4096));
          default: low_val = LOW_W'($urandom());
        endcase
        case ($urandom_range(0, 15))
          0: cnt = '0;
          1, 2: cnt = COUNT_W'($urandom_range(SEG_LEN_DEF + 1, 2047));
          3, 4, 5: cnt = COUNT_W'($urandom_range(1, 64));
          default: cnt = COUNT_W'($urandom_range(1, SEG_LEN_DEF));
        endcase
        write_reg(REG_SEG_LOW, CFG_DATA_W'(low_val));
        write_reg(REG_SEG_COUNT, CFG_DATA_W'(cnt));
      end
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) send_prime($urandom_range(0, PRIME_MAX), $urandom_range(0, 1) == 1);
      end else begin
        len = $urandom_range(1, 8);
        p = 2;
        for (int i = 0; i < len; i++) begin
          send_prime(p, i == len - 1);
          if ($urandom_range(0, 3) == 0) begin
            p = prime_at_or_above($urandom_range(p + 1, PRIME_MAX));
          end else begin
            p = prime_at_or_above(p + 1);
          end
        end
      end
    end
    settle();

    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire

[segmented_prime_sieve_core.f]
rtl/sps_pkg.sv
rtl/sps_fifo.sv
rtl/sps_front.sv
rtl/sps_back.sv
rtl/segmented_prime_sieve_core.sv
tb/tb_top.sv
